// File: sv/psprl_pkg.sv
// Shared constants, types and register codes of the per-source alert rate limiter.
package psprl_pkg;

    localparam int NUM_SOURCES    = 64;
    localparam int SRC_BITS       = $clog2(NUM_SOURCES);
    localparam int TIME_BITS      = 32;
    localparam int CNT_BITS       = 16;
    localparam int INTERVAL_BITS  = 16;
    localparam int WINDOW_BITS    = 16;
    localparam int BUDGET_BITS    = 8;
    localparam int AGE_BITS       = 32;
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [CFG_INDEX_BITS-1:0] REG_POPUP_INTERVAL = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_BURST_WINDOW   = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] REG_BURST_BUDGET   = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_AGE        = CFG_INDEX_BITS'(3);

    localparam logic [INTERVAL_BITS-1:0] POPUP_INTERVAL_RST = INTERVAL_BITS'(30);
    localparam logic [WINDOW_BITS-1:0]   BURST_WINDOW_RST   = WINDOW_BITS'(20);
    localparam logic [BUDGET_BITS-1:0]   BURST_BUDGET_RST   = BUDGET_BITS'(3);
    localparam logic [AGE_BITS-1:0]      MAX_AGE_RST        = AGE_BITS'(24 * 60 * 60);

    localparam logic [CNT_BITS-1:0] SILENCE_MAX = '1;

    typedef struct packed {
        logic [INTERVAL_BITS-1:0] popup_interval;
        logic [WINDOW_BITS-1:0]   burst_window;
        logic [BUDGET_BITS-1:0]   burst_budget;
        logic [AGE_BITS-1:0]      max_age;
    } cfg_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] last_grant_time;
        logic [CNT_BITS-1:0]  silenced_count;
        logic [TIME_BITS-1:0] last_access_time;
    } entry_t;

    typedef struct packed {
        logic                en;
        logic [SRC_BITS-1:0] addr;
    } tbl_rd_t;

    typedef struct packed {
        logic                en;
        logic [SRC_BITS-1:0] addr;
        entry_t              entry;
    } tbl_wr_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

// File: sv/psprl_if.sv
// Handshake channel interfaces: event requests, alert decisions and register writes.
interface psprl_req_if;
    logic                           valid;
    logic                           ready;
    logic [psprl_pkg::SRC_BITS-1:0] source_index;
    logic [31:0]                    now_time;
    logic                           wants_alert;

    modport source (output valid, output source_index, output now_time, output wants_alert,
                    input ready);
    modport sink (input valid, input source_index, input now_time, input wants_alert,
                  output ready);
endinterface

interface psprl_rsp_if;
    logic        valid;
    logic        ready;
    logic        alert_granted;
    logic [15:0] coalesced_count;

    modport source (output valid, output alert_granted, output coalesced_count, input ready);
    modport sink (input valid, input alert_granted, input coalesced_count, output ready);
endinterface

interface psprl_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [psprl_pkg::CFG_INDEX_BITS-1:0] index;
    logic [psprl_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/psprl_cfg_regs.sv
// Configuration register bank written through the register channel.
module psprl_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    psprl_cfg_if.sink         cfg,
    output psprl_pkg::cfg_t   regs
);
    import psprl_pkg::*;

    cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.popup_interval <= POPUP_INTERVAL_RST;
            regs_reg.burst_window   <= BURST_WINDOW_RST;
            regs_reg.burst_budget   <= BURST_BUDGET_RST;
            regs_reg.max_age        <= MAX_AGE_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_POPUP_INTERVAL: regs_reg.popup_interval <= cfg.data[INTERVAL_BITS-1:0];
                REG_BURST_WINDOW:   regs_reg.burst_window   <= cfg.data[WINDOW_BITS-1:0];
                REG_BURST_BUDGET:   regs_reg.burst_budget   <= cfg.data[BUDGET_BITS-1:0];
                REG_MAX_AGE:        regs_reg.max_age        <= cfg.data[AGE_BITS-1:0];
                default:            ;
            endcase
        end
    end

endmodule

// File: sv/psprl_table.sv
// Per-source state memory with registered read and reset-cleared entry valid bits.
module psprl_table (
    input  logic               clk,
    input  logic               rst_n,
    input  psprl_pkg::tbl_rd_t rd,
    input  psprl_pkg::tbl_wr_t wr,
    output psprl_pkg::entry_t  rd_entry
);
    import psprl_pkg::*;

    entry_t                 mem [NUM_SOURCES];
    entry_t                 rd_data_reg;
    logic                   rd_valid_reg;
    logic [NUM_SOURCES-1:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.entry;
        end
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd.en)
            begin
                rd_valid_reg <= valid_reg[rd.addr];
            end
        end
    end

    // never-written entries read as zero
    assign rd_entry = rd_valid_reg ? rd_data_reg : '0;

endmodule

// File: sv/psprl_ctrl.sv
// Sequencer, burst window state, grant decision and result register.
module psprl_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    psprl_req_if.sink          req,
    psprl_rsp_if.source        rsp,
    input  psprl_pkg::cfg_t    regs,
    output psprl_pkg::tbl_rd_t rd,
    output psprl_pkg::tbl_wr_t wr,
    input  psprl_pkg::entry_t  rd_entry
);
    import psprl_pkg::*;

    state_t               state_reg;
    state_t               state_next;
    logic [SRC_BITS-1:0]  src_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic                 wants_reg;
    logic [TIME_BITS-1:0] win_start_reg;
    logic [TIME_BITS-1:0] win_start_next;
    logic [BUDGET_BITS-1:0] win_grants_reg;
    logic [BUDGET_BITS-1:0] win_grants_next;
    logic                 out_valid_reg;
    logic                 granted_reg;
    logic [CNT_BITS-1:0]  count_reg;

    logic                 accept;
    logic                 exec_go;
    logic                 restart;
    logic [BUDGET_BITS-1:0] grants_eff;
    logic                 aged;
    logic [TIME_BITS-1:0] last_eff;
    logic [CNT_BITS-1:0]  sil_eff;
    logic [CNT_BITS-1:0]  sil_inc;
    logic                 interval_ok;
    logic                 grant;

    assign accept = req.valid && req.ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_EXEC;
            ST_EXEC: if (exec_go) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req.ready = 1'b0;
        exec_go   = 1'b0;
        case (state_reg)
            ST_IDLE: req.ready = 1'b1;
            ST_EXEC: exec_go   = !out_valid_reg || rsp.ready;
            default: ;
        endcase
    end

    always_comb
    begin
        restart = (now_reg < win_start_reg) ||
                  ((now_reg - win_start_reg) >= TIME_BITS'(regs.burst_window));
        grants_eff = restart ? '0 : win_grants_reg;

        aged = (now_reg < rd_entry.last_access_time) ||
               ((now_reg - rd_entry.last_access_time) > TIME_BITS'(regs.max_age));
        last_eff = aged ? '0 : rd_entry.last_grant_time;
        sil_eff  = aged ? '0 : rd_entry.silenced_count;
        sil_inc  = (sil_eff == SILENCE_MAX) ? sil_eff : CNT_BITS'(sil_eff + 1'b1);

        interval_ok = (now_reg < last_eff) ||
                      ((now_reg - last_eff) >= TIME_BITS'(regs.popup_interval));
        grant = wants_reg && interval_ok && (grants_eff < regs.burst_budget);

        rd.en   = accept;
        rd.addr = req.source_index;

        wr.en   = exec_go && wants_reg;
        wr.addr = src_reg;
        wr.entry.last_access_time = now_reg;
        if (grant)
        begin
            wr.entry.last_grant_time = now_reg;
            wr.entry.silenced_count  = '0;
        end
        else
        begin
            wr.entry.last_grant_time = last_eff;
            wr.entry.silenced_count  = sil_inc;
        end

        win_start_next  = win_start_reg;
        win_grants_next = win_grants_reg;
        if (exec_go && wants_reg)
        begin
            win_start_next  = restart ? now_reg : win_start_reg;
            win_grants_next = grant ? BUDGET_BITS'(grants_eff + 1'b1) : grants_eff;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            src_reg   <= req.source_index;
            now_reg   <= req.now_time;
            wants_reg <= req.wants_alert;
        end
        if (exec_go)
        begin
            granted_reg <= grant;
            count_reg   <= grant ? sil_eff : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            win_start_reg  <= '0;
            win_grants_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            win_start_reg  <= win_start_next;
            win_grants_reg <= win_grants_next;
            if (exec_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.alert_granted   = granted_reg;
    assign rsp.coalesced_count = count_reg;

endmodule

// File: sv/per_source_popup_rate_limiter.sv
// Top level of the per-source alert rate limiter.
//
// Channels: req carries events (source_index, now_time, wants_alert); rsp returns
// one decision per event (alert_granted, coalesced_count); cfg writes the registers
// popup_interval (0), burst_window (1), burst_budget (2) and max_age (3).
// Every handshake moves one transaction at a rising edge with valid and ready high.
// An event is accepted in ST_IDLE, which also issues the read of the source's
// table entry; ST_EXEC then decides, writes the entry back and loads the result
// register. No new event is accepted until the last one is decided, set by the
// read-modify-write of the source table through its single registered read port.
// A new event is accepted while a decision still waits in the result register;
// if rsp stays stalled the decision of that event holds until the register frees.
// Reset restores the register defaults, clears the burst window and marks every
// table entry as zero through per-entry valid bits, so no clearing pass is needed.
// cfg is always ready; write registers only while no event is in flight.
module per_source_popup_rate_limiter (
    input  logic        clk,
    input  logic        rst_n,
    psprl_req_if.sink   req,
    psprl_rsp_if.source rsp,
    psprl_cfg_if.sink   cfg
);
    import psprl_pkg::*;

    cfg_t    regs;
    tbl_rd_t rd;
    tbl_wr_t wr;
    entry_t  rd_entry;

    psprl_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    psprl_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd       (rd),
        .wr       (wr),
        .rd_entry (rd_entry)
    );

    psprl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .regs     (regs),
        .rd       (rd),
        .wr       (wr),
        .rd_entry (rd_entry)
    );

endmodule

// File: sv/psprl_checker.sv
// Port-level checker for the rate limiter and its bind to the top level.
module psprl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        alert_granted,
    input logic [15:0] coalesced_count
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(alert_granted) &&
        $stable(coalesced_count))
        else $error("decision changed while stalled");

    a_deny_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !alert_granted |-> coalesced_count == 16'd0)
        else $error("denied transaction reports a silenced count");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second event accepted before table write-back");

    a_rsp_from_req: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
        else $error("decision appeared without an accepted event");

endmodule

bind per_source_popup_rate_limiter psprl_checker u_psprl_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .alert_granted   (rsp.alert_granted),
    .coalesced_count (rsp.coalesced_count)
);
